// ===== sv/ppra_pkg.sv =====
// ----------------------------------------------------------------------------
// ppra_pkg
// Shared types and codes for the preemptive priority radio arbiter.
// ----------------------------------------------------------------------------
package ppra_pkg;

  localparam int ID_W      = 3;
  localparam int PRIO_IN_W = 5;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 4;
  localparam int WAIT_W    = 3;
  localparam int REG_W     = 8;

  localparam logic [REG_W-1:0] REG_RESET = 8'd254;

  // command codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_UNKNOWN     = 4'd0,
    ST_GRANT_FREE  = 4'd1,
    ST_REGRANT     = 4'd2,
    ST_PREEMPT     = 4'd3,
    ST_QUEUED      = 4'd4,
    ST_DROPPED     = 4'd5,
    ST_NEXT_GRANT  = 4'd6,
    ST_STANDBY     = 4'd7,
    ST_REL_IGNORED = 4'd8
  } status_e;

  // classified word from the front end
  typedef struct packed {
    logic                 command;
    logic                 known;
    logic [ID_W-1:0]      id;
    logic [PRIO_IN_W-1:0] prio;
    logic [WORD_W-1:0]    freq;
    logic [WORD_W-1:0]    bw;
    logic [MODE_W-1:0]    mode;
  } req_t;

  // result word
  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   granted;
    logic [ID_W-1:0]   preempted;
    logic              apply;
    logic [WORD_W-1:0] freq;
    logic [WORD_W-1:0] bw;
    logic [MODE_W-1:0] mode;
    logic              standby;
    logic [WAIT_W-1:0] waiting;
  } res_t;

endpackage

// ===== sv/ppra_front.sv =====
// ----------------------------------------------------------------------------
// ppra_front
// Holds the id registration mask, classifies incoming words and buffers
// them in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module ppra_front #(
  parameter int PRIO_BITS = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppra_pkg::REG_W-1:0]      cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            command_i,
  input  logic [ppra_pkg::ID_W-1:0]       task_id_i,
  input  logic [ppra_pkg::PRIO_IN_W-1:0]  task_priority_i,
  input  logic [ppra_pkg::WORD_W-1:0]     freq_hz_i,
  input  logic [ppra_pkg::WORD_W-1:0]     bw_hz_i,
  input  logic [ppra_pkg::MODE_W-1:0]     radio_mode_i,
  output ppra_pkg::req_t                  req_o,
  output logic                            req_valid_o,
  input  logic                            req_pop_i
);
  import ppra_pkg::*;

  localparam int PrioW = (PRIO_BITS < PRIO_IN_W) ? PRIO_BITS : PRIO_IN_W;
  localparam logic [PRIO_IN_W-1:0] PrioMask = PRIO_IN_W'((1 << PrioW) - 1);

  logic [REG_W-1:0] reg_q;
  req_t             slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  req_t             item;
  logic             do_push, do_pop;

  always_comb begin
    item.command = command_i;
    item.known   = (task_id_i != '0) && reg_q[task_id_i];
    item.id      = task_id_i;
    item.prio    = task_priority_i & PrioMask;
    item.freq    = freq_hz_i;
    item.bw      = bw_hz_i;
    item.mode    = radio_mode_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = req_pop_i && req_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= REG_RESET;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        reg_q <= cfg_wdata_i;
      end
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item;
    end
  end

endmodule

// ===== sv/ppra_back.sv =====
// ----------------------------------------------------------------------------
// ppra_back
// Owner tracking, waiting-request FIFO and result register. Each word passes through
// a read state (FIFO head fetch) and an execute state.
// ----------------------------------------------------------------------------
module ppra_back #(
  parameter int QUEUE_DEPTH = 4,
  parameter int PRIO_BITS   = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppra_pkg::req_t req_i,
  input  logic           req_valid_i,
  output logic           req_pop_o,
  output ppra_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           res_pop_i
);
  import ppra_pkg::*;

  localparam int PrioW = (PRIO_BITS < PRIO_IN_W) ? PRIO_BITS : PRIO_IN_W;
  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PrioW-1:0]  prio;
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] freq;
    logic [WORD_W-1:0] bw;
  } entry_t;

  typedef enum logic {B_READ, B_EXEC} state_e;

  state_e           state_q;
  logic [ID_W-1:0]  owner_q, owner_n;
  logic [PrioW-1:0] prio_q, prio_n;
  logic [PtrW-1:0]  head_q, head_n, tail_q, tail_n;
  logic [CntW-1:0]  fill_q, fill_n;
  res_t             res_q, res_n;
  logic             res_valid_q;
  entry_t           mem_q [QUEUE_DEPTH];
  entry_t           rd_q;
  entry_t           wr_entry;
  logic             exec_fire, do_enq;
  logic [PrioW-1:0] req_prio;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign exec_fire   = (state_q == B_EXEC) && (!res_valid_q || res_pop_i);
  assign req_pop_o   = exec_fire;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
  assign req_prio    = req_i.prio[PrioW-1:0];

  always_comb begin
    wr_entry.id   = req_i.id;
    wr_entry.prio = req_prio;
    wr_entry.mode = req_i.mode;
    wr_entry.freq = req_i.freq;
    wr_entry.bw   = req_i.bw;
  end

  always_comb begin
    res_n   = '0;
    owner_n = owner_q;
    prio_n  = prio_q;
    head_n  = head_q;
    tail_n  = tail_q;
    fill_n  = fill_q;
    do_enq  = 1'b0;
    if (req_i.command == CMD_REQUEST) begin
      priority if (!req_i.known) begin
        res_n.status = ST_UNKNOWN;
      end else if (owner_q == '0) begin
        owner_n       = req_i.id;
        prio_n        = req_prio;
        res_n.status  = ST_GRANT_FREE;
        res_n.granted = req_i.id;
        res_n.apply   = 1'b1;
        res_n.freq    = req_i.freq;
        res_n.bw      = req_i.bw;
        res_n.mode    = req_i.mode;
      end else if (owner_q == req_i.id) begin
        res_n.status  = ST_REGRANT;
        res_n.granted = req_i.id;
      end else if (req_prio > prio_q) begin
        owner_n         = req_i.id;
        prio_n          = req_prio;
        res_n.status    = ST_PREEMPT;
        res_n.granted   = req_i.id;
        res_n.preempted = owner_q;
        res_n.apply     = 1'b1;
        res_n.freq      = req_i.freq;
        res_n.bw        = req_i.bw;
        res_n.mode      = req_i.mode;
      end else if (fill_q == CntW'(QUEUE_DEPTH)) begin
        res_n.status = ST_DROPPED;
      end else begin
        do_enq       = 1'b1;
        tail_n       = ptr_next(tail_q);
        fill_n       = fill_q + 1'b1;
        res_n.status = ST_QUEUED;
      end
    end else begin
      priority if (req_i.id != owner_q) begin
        res_n.status = ST_REL_IGNORED;
      end else if (fill_q != '0) begin
        head_n        = ptr_next(head_q);
        fill_n        = fill_q - 1'b1;
        owner_n       = rd_q.id;
        prio_n        = rd_q.prio;
        res_n.status  = ST_NEXT_GRANT;
        res_n.granted = rd_q.id;
        res_n.apply   = 1'b1;
        res_n.freq    = rd_q.freq;
        res_n.bw      = rd_q.bw;
        res_n.mode    = rd_q.mode;
      end else begin
        owner_n       = '0;
        prio_n        = '0;
        res_n.status  = ST_STANDBY;
        res_n.standby = 1'b1;
      end
    end
    res_n.waiting = WAIT_W'(fill_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_READ;
      owner_q     <= '0;
      prio_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_READ: begin
          if (req_valid_i) begin
            state_q <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (exec_fire) begin
            state_q <= B_READ;
          end
        end
        default: state_q <= B_READ;
      endcase
      if (exec_fire) begin
        owner_q     <= owner_n;
        prio_q      <= prio_n;
        head_q      <= head_n;
        tail_q      <= tail_n;
        fill_q      <= fill_n;
        res_q       <= res_n;
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // waiting-request store, registered head read
  always_ff @(posedge clk_i) begin
    if (exec_fire && do_enq) begin
      mem_q[tail_q] <= wr_entry;
    end
    rd_q <= mem_q[head_q];
  end

endmodule

// ===== sv/priority_preempt_radio_arbiter.sv =====
// ----------------------------------------------------------------------------
// priority_preempt_radio_arbiter
// Preemptive priority arbiter for one shared radio with a waiting FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the request word with push high; it is taken on a
//   clock edge with full low. A two-entry buffer sits behind it.
//   Result channel: while empty is low the oldest result word is on the
//   output ports; pop high with empty low takes it.
//   Config: cfg_we_i writes the id registration mask (bit per id, bit 0
//   unused). Write it only while no word is in flight.
//   Flow: a word taken into the two-entry buffer passes the back end's read
//   state (registered head read of the waiting FIFO) and then its execute
//   state; the back end takes no new word until the last one has executed.
//   Reset: no owner, FIFO empty, mask = 0xFE, both buffers empty.
//   Stall: a held result blocks the back end only; the front keeps taking
//   words until its two-entry buffer fills, then full rises.
// ----------------------------------------------------------------------------
module priority_preempt_radio_arbiter #(
  parameter int QUEUE_DEPTH = 4,
  parameter int PRIO_BITS   = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppra_pkg::REG_W-1:0]      cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            command_i,
  input  logic [ppra_pkg::ID_W-1:0]       task_id_i,
  input  logic [ppra_pkg::PRIO_IN_W-1:0]  task_priority_i,
  input  logic [ppra_pkg::WORD_W-1:0]     freq_hz_i,
  input  logic [ppra_pkg::WORD_W-1:0]     bw_hz_i,
  input  logic [ppra_pkg::MODE_W-1:0]     radio_mode_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [ppra_pkg::STATUS_W-1:0]   status_o,
  output logic [ppra_pkg::ID_W-1:0]       granted_task_o,
  output logic [ppra_pkg::ID_W-1:0]       preempted_task_o,
  output logic                            apply_settings_o,
  output logic [ppra_pkg::WORD_W-1:0]     tune_freq_hz_o,
  output logic [ppra_pkg::WORD_W-1:0]     tune_bw_hz_o,
  output logic [ppra_pkg::MODE_W-1:0]     grant_mode_o,
  output logic                            enter_standby_o,
  output logic [ppra_pkg::WAIT_W-1:0]     waiting_count_o
);
  import ppra_pkg::*;

  req_t req;
  logic req_valid, req_pop;
  res_t res;
  logic res_valid;

  // front end: registration mask, classification, word buffer
  ppra_front #(
    .PRIO_BITS(PRIO_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .freq_hz_i       (freq_hz_i),
    .bw_hz_i         (bw_hz_i),
    .radio_mode_i    (radio_mode_i),
    .req_o           (req),
    .req_valid_o     (req_valid),
    .req_pop_i       (req_pop)
  );

  // back end: ownership decisions, waiting FIFO, result register
  ppra_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PRIO_BITS  (PRIO_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty            = !res_valid;
  assign status_o         = res.status;
  assign granted_task_o   = res.granted;
  assign preempted_task_o = res.preempted;
  assign apply_settings_o = res.apply;
  assign tune_freq_hz_o   = res.freq;
  assign tune_bw_hz_o     = res.bw;
  assign grant_mode_o     = res.mode;
  assign enter_standby_o  = res.standby;
  assign waiting_count_o  = res.waiting;

  // fresh settings only come with a fresh grant
  a_apply_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && apply_settings_o |-> granted_task_o != '0 &&
      (status_o == ST_GRANT_FREE || status_o == ST_PREEMPT || status_o == ST_NEXT_GRANT))
    else $error("settings applied without a fresh grant");

  // a preempted owner is always distinct from the new owner
  a_preempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && preempted_task_o != '0 |->
      status_o == ST_PREEMPT && preempted_task_o != granted_task_o && apply_settings_o)
    else $error("bad preemption result");

  // standby only when the waiting FIFO is empty and nobody is granted
  a_standby: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && enter_standby_o |->
      status_o == ST_STANDBY && waiting_count_o == '0 && granted_task_o == '0)
    else $error("standby with waiting requests or a grant");

  // a held result word must not change under a stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(granted_task_o))
    else $error("result word changed while stalled");

endmodule
